// ----- rtl/core/spsu_pkg.sv -----
// spsu_pkg: types, constants and command codes for the spiking p system step unit
// no dependencies
package spsu_pkg;
  localparam int NEURONS_DEF    = 16;
  localparam int RULES_DEF      = 32;
  localparam int SPIKE_BITS_DEF = 16;
  localparam int DELAY_BITS_DEF = 8;
  localparam int REPORT_MAX     = 16;
  localparam int CMD_W          = 2;
  localparam int IDX_W          = 4;
  localparam int FLD_W          = 16;
  localparam int RIDX_W         = 5;
  localparam int DLY_IN_W       = 8;

  typedef enum logic [CMD_W-1:0] {
    CMD_RULE  = 2'd0,
    CMD_SET   = 2'd1,
    CMD_TICK  = 2'd2,
    CMD_NONE  = 2'd3
  } cmd_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_OPEN,
    ST_RULE,
    ST_APPLY,
    ST_REPORT
  } state_t;

  typedef struct packed {
    logic wr_rule;
    logic wr_spk;
    logic tick_start;
    logic rule_step;
    logic apply_step;
    logic rep_load;
  } ctl_t;

  typedef struct packed {
    logic rule_done;
    logic apply_done;
    logic rep_done;
  } sts_t;
endpackage

// ----- rtl/core/spiking_p_system_step_unit.sv -----
// spiking_p_system_step_unit: top level joining spsu_ctrl and spsu_dp
// depends on spsu_pkg, spsu_ctrl, spsu_dp
//
// channel  dir  contents
// in_      in   tdata: cmd, rule_index, source, dest, forgetting, consumed, produced,
//               threshold, delay, neuron_index, spike_value
// out_     out  tdata: neuron_id, spikes, closed; tlast: last
//
// rule write and spike set are done without leaving idle; a tick walks the rule memory
// (one rule memory read a cycle), then applies the deltas neuron by neuron and makes
// min(NEURONS,16) report transfers, one a cycle when out_tready stays high.
// synchronous active-low reset clears valid bits, spike counts and delays.
// the input is not accepted during a tick; a stalled output holds the tick.
module spiking_p_system_step_unit #(
  parameter int NEURONS    = spsu_pkg::NEURONS_DEF,
  parameter int RULES      = spsu_pkg::RULES_DEF,
  parameter int SPIKE_BITS = spsu_pkg::SPIKE_BITS_DEF,
  parameter int DELAY_BITS = spsu_pkg::DELAY_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  // cmd[1:0] rule_index[6:2] source[10:7] dest[14:11] forgetting[15] consumed[31:16]
  // produced[47:32] threshold[63:48] delay[71:64] neuron_index[75:72] spike_value[91:76]
  input  logic [95:0] in_tdata,
  output logic        out_tvalid,
  input  logic        out_tready,
  // neuron_id[3:0] spikes[19:4] closed[20]
  output logic [23:0] out_tdata,
  output logic        out_tlast
);
  spsu_pkg::ctl_t ctl;
  spsu_pkg::sts_t sts;
  logic out_busy;

  spsu_ctrl u_ctrl (
    .clk, .rst_n, .in_tvalid, .in_tready,
    .cmd(in_tdata[1:0]), .out_busy, .sts, .ctl
  );

  spsu_dp #(.NEURONS(NEURONS), .RULES(RULES), .SPIKE_BITS(SPIKE_BITS),
            .DELAY_BITS(DELAY_BITS)) u_dp (
    .clk, .rst_n, .ctl, .sts,
    .rule_index(in_tdata[6:2]), .source_neuron(in_tdata[10:7]),
    .dest_neuron(in_tdata[14:11]), .forgetting(in_tdata[15]),
    .consumed(in_tdata[31:16]), .produced(in_tdata[47:32]),
    .threshold(in_tdata[63:48]), .delay(in_tdata[71:64]),
    .neuron_index(in_tdata[75:72]), .spike_value(in_tdata[91:76]),
    .out_tvalid, .out_tready, .out_tdata, .out_tlast, .out_busy
  );
endmodule

// ----- rtl/core/spsu_ctrl.sv -----
// spsu_ctrl: sequencer for rule write, spike set and tick phases
// depends on spsu_pkg
module spsu_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_tvalid,
  output logic              in_tready,
  input  logic [1:0]        cmd,
  input  logic              out_busy,
  input  spsu_pkg::sts_t    sts,
  output spsu_pkg::ctl_t    ctl
);
  spsu_pkg::state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= spsu_pkg::ST_IDLE;
    else state_r <= state_nxt;
  end

  always_comb begin
    state_nxt = state_r;
    ctl = '0;
    in_tready = 1'b0;
    case (state_r)
      spsu_pkg::ST_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          case (cmd)
            spsu_pkg::CMD_RULE: ctl.wr_rule = 1'b1;
            spsu_pkg::CMD_SET:  ctl.wr_spk = 1'b1;
            spsu_pkg::CMD_TICK: begin
              ctl.tick_start = 1'b1;
              state_nxt = spsu_pkg::ST_RULE;
            end
            default: ;
          endcase
        end
      end
      spsu_pkg::ST_RULE: begin
        ctl.rule_step = 1'b1;
        if (sts.rule_done) state_nxt = spsu_pkg::ST_APPLY;
      end
      spsu_pkg::ST_APPLY: begin
        ctl.apply_step = 1'b1;
        if (sts.apply_done) state_nxt = spsu_pkg::ST_REPORT;
      end
      spsu_pkg::ST_REPORT: begin
        if (!out_busy) begin
          ctl.rep_load = 1'b1;
          if (sts.rep_done) state_nxt = spsu_pkg::ST_IDLE;
        end
      end
      default: state_nxt = spsu_pkg::ST_IDLE;
    endcase
  end
endmodule

// ----- rtl/core/spsu_dp.sv -----
// spsu_dp: rule memory, neuron registers, delta accumulation and report output
// depends on spsu_pkg
module spsu_dp #(
  parameter int NEURONS    = spsu_pkg::NEURONS_DEF,
  parameter int RULES      = spsu_pkg::RULES_DEF,
  parameter int SPIKE_BITS = spsu_pkg::SPIKE_BITS_DEF,
  parameter int DELAY_BITS = spsu_pkg::DELAY_BITS_DEF
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  spsu_pkg::ctl_t            ctl,
  output spsu_pkg::sts_t            sts,
  input  logic [4:0]                rule_index,
  input  logic [3:0]                source_neuron,
  input  logic [3:0]                dest_neuron,
  input  logic                      forgetting,
  input  logic [15:0]               consumed,
  input  logic [15:0]               produced,
  input  logic [15:0]               threshold,
  input  logic [7:0]                delay,
  input  logic [3:0]                neuron_index,
  input  logic [15:0]               spike_value,
  output logic                      out_tvalid,
  input  logic                      out_tready,
  output logic [23:0]               out_tdata,
  output logic                      out_tlast,
  output logic                      out_busy
);
  localparam int RW = (RULES > 1) ? $clog2(RULES) : 1;
  localparam int NW = (NEURONS > 1) ? $clog2(NEURONS) : 1;
  localparam int DW = SPIKE_BITS + 18;
  localparam int NREP = (NEURONS < spsu_pkg::REPORT_MAX) ? NEURONS : spsu_pkg::REPORT_MAX;
  localparam logic [SPIKE_BITS-1:0] SMAX = {SPIKE_BITS{1'b1}};
  localparam logic [DELAY_BITS-1:0] DMAX = {DELAY_BITS{1'b1}};
  localparam int TW = 4 + 16 + 16 + DELAY_BITS;
  localparam int PW = 4 + 1 + 16;

  logic [TW-1:0] trig_mem [RULES];
  logic [PW-1:0] prod_mem [RULES];
  logic [RULES-1:0] rvalid_r;
  logic [TW-1:0] trig_q;
  logic [PW-1:0] prod_q;
  logic q_valid_r;
  logic [RW:0] rcnt_r;
  logic [NW:0] ncnt_r;
  logic [SPIKE_BITS-1:0] spk_r [NEURONS];
  logic [DELAY_BITS-1:0] dly_r [NEURONS];
  logic signed [DW-1:0] delta_r [NEURONS];
  logic [NEURONS-1:0] closed_r, fired_r;
  logic [4:0] rep_r;
  logic [DELAY_BITS-1:0] dly_sat;
  logic [SPIKE_BITS-1:0] spk_sat;

  always_comb begin
    if (DELAY_BITS < 8 && (delay >> DELAY_BITS) != 8'd0) dly_sat = DMAX;
    else dly_sat = DELAY_BITS'(delay);
    if (SPIKE_BITS < 16 && (spike_value >> SPIKE_BITS) != 16'd0) spk_sat = SMAX;
    else spk_sat = SPIKE_BITS'(spike_value);
  end

  always_ff @(posedge clk) begin
    if (ctl.wr_rule && 32'(rule_index) < RULES) begin
      trig_mem[rule_index[RW-1:0]] <= {dly_sat, consumed, threshold, source_neuron};
      prod_mem[rule_index[RW-1:0]] <= {produced, forgetting, dest_neuron};
    end
    trig_q <= trig_mem[rcnt_r[RW-1:0]];
    prod_q <= prod_mem[rcnt_r[RW-1:0]];
  end

  logic [3:0] q_src, q_dst;
  logic [15:0] q_thr, q_con, q_amt;
  logic [DELAY_BITS-1:0] q_dly;
  logic q_fgt, q_fire;
  assign q_src = trig_q[3:0];
  assign q_thr = trig_q[19:4];
  assign q_con = trig_q[35:20];
  assign q_dly = trig_q[TW-1:36];
  assign q_dst = prod_q[3:0];
  assign q_fgt = prod_q[4];
  assign q_amt = prod_q[20:5];
  always_comb begin
    q_fire = 1'b0;
    if (q_valid_r && 32'(q_src) < NEURONS)
      q_fire = !closed_r[q_src[NW-1:0]] && !fired_r[q_src[NW-1:0]] &&
               (32'(spk_r[q_src[NW-1:0]]) >= 32'(q_thr));
  end

  logic signed [DW-1:0] sum;
  logic [SPIKE_BITS-1:0] nv;
  always_comb begin
    sum = $signed({{(DW-SPIKE_BITS){1'b0}}, spk_r[ncnt_r[NW-1:0]]}) + delta_r[ncnt_r[NW-1:0]];
    if (sum < 0) nv = '0;
    else if (sum > $signed({{(DW-SPIKE_BITS){1'b0}}, SMAX})) nv = SMAX;
    else nv = sum[SPIKE_BITS-1:0];
  end

  assign sts.rule_done  = (32'(rcnt_r) == RULES + 1);
  assign sts.apply_done = (32'(ncnt_r) == NEURONS - 1);
  assign sts.rep_done   = (32'(rep_r) == NREP - 1);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rvalid_r <= '0;
      q_valid_r <= 1'b0;
      rcnt_r <= '0;
      ncnt_r <= '0;
      rep_r <= '0;
      out_tvalid <= 1'b0;
      for (int i = 0; i < NEURONS; i++) begin
        spk_r[i] <= '0;
        dly_r[i] <= '0;
      end
    end else begin
      if (ctl.wr_rule && 32'(rule_index) < RULES) rvalid_r[rule_index[RW-1:0]] <= 1'b1;
      if (ctl.wr_spk && 32'(neuron_index) < NEURONS) spk_r[neuron_index[NW-1:0]] <= spk_sat;
      if (ctl.tick_start) begin
        rcnt_r <= '0;
        ncnt_r <= '0;
        rep_r <= '0;
        q_valid_r <= 1'b0;
        for (int i = 0; i < NEURONS; i++) begin
          delta_r[i] <= '0;
          fired_r[i] <= 1'b0;
          closed_r[i] <= (dly_r[i] != '0);
          if (dly_r[i] != '0) dly_r[i] <= dly_r[i] - 1'b1;
        end
      end
      if (ctl.rule_step) begin
        rcnt_r <= rcnt_r + 1'b1;
        q_valid_r <= (32'(rcnt_r) < RULES) && rvalid_r[rcnt_r[RW-1:0]];
        if (q_fire) begin
          fired_r[q_src[NW-1:0]] <= 1'b1;
          if (q_dly != '0) dly_r[q_src[NW-1:0]] <= q_dly;
          if (!q_fgt && 32'(q_dst) < NEURONS && q_dst == q_src)
            delta_r[q_src[NW-1:0]] <= delta_r[q_src[NW-1:0]] - DW'(q_con) + DW'(q_amt);
          else begin
            delta_r[q_src[NW-1:0]] <= delta_r[q_src[NW-1:0]] - DW'(q_con);
            if (!q_fgt && 32'(q_dst) < NEURONS)
              delta_r[q_dst[NW-1:0]] <= delta_r[q_dst[NW-1:0]] + DW'(q_amt);
          end
        end
      end
      if (ctl.apply_step) begin
        ncnt_r <= ncnt_r + 1'b1;
        if (!closed_r[ncnt_r[NW-1:0]]) spk_r[ncnt_r[NW-1:0]] <= nv;
      end
      if (ctl.rep_load) begin
        out_tvalid <= 1'b1;
        rep_r <= rep_r + 1'b1;
        out_tlast <= sts.rep_done;
        out_tdata <= {3'd0, closed_r[rep_r[NW-1:0]],
                      16'(spk_r[rep_r[NW-1:0]]), rep_r[3:0]};
      end else if (out_tvalid && out_tready) begin
        out_tvalid <= 1'b0;
      end
    end
  end

  assign out_busy = out_tvalid && !out_tready;
endmodule
